// File: hdl/matrix_inverse_4x4_unit_macros.svh
// Assertion helpers for the 4x4 matrix inverse unit.
`ifndef MATRIX_INVERSE_4X4_UNIT_MACROS_SVH
`define MATRIX_INVERSE_4X4_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define MINV_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("minv: property violated");
`define MINV_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("minv: forbidden condition seen");
`else
`define MINV_ASSERT(label, clk, rst_n, prop)
`define MINV_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

// File: hdl/minv_pkg.sv
`default_nettype none

package minv_pkg;

  localparam int unsigned ElemW    = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned OpndW    = ElemW + 1;
  localparam int unsigned ProdW    = 2 * OpndW;
  localparam int unsigned AccW     = ElemW + 4;
  localparam int unsigned DivW     = 2 * FracBits + 2;
  localparam int unsigned DivCntW  = $clog2(DivW + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_ISSUE,
    ST_WAIT,
    ST_COF_WR,
    ST_DET_WR,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    PH_MINOR,
    PH_DET,
    PH_INV
  } phase_e;

  typedef enum logic [1:0] {
    OPA_MAT,
    OPA_TMP,
    OPA_COF
  } opa_sel_e;

  typedef enum logic [1:0] {
    OPB_MAT,
    OPB_COF,
    OPB_RECIP
  } opb_sel_e;

  typedef enum logic [1:0] {
    DST_TMP,
    DST_ADD,
    DST_SUB,
    DST_OUT
  } dest_e;

  typedef struct packed {
    logic       issue;
    opa_sel_e   opa;
    opb_sel_e   opb;
    dest_e      dest;
    logic [3:0] mat_addr0;
    logic [3:0] mat_addr1;
    logic [3:0] cof_addr;
    logic [1:0] slot;
    logic       acc_clr;
    logic       cof_wr;
    logic       cof_neg;
    logic       det_wr;
    logic       div_start;
    logic       load;
    logic [1:0] load_col;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic div_busy;
  } sts_t;

  // Element positions of the six Sarrus triple products, {third, second, first}.
  function automatic logic [2:0][3:0] term_ks(input logic [2:0] t);
    logic [2:0][3:0] ks;
    unique case (t)
      3'd0:    ks = {4'd8, 4'd4, 4'd0};
      3'd1:    ks = {4'd6, 4'd5, 4'd1};
      3'd2:    ks = {4'd7, 4'd3, 4'd2};
      3'd3:    ks = {4'd2, 4'd4, 4'd6};
      3'd4:    ks = {4'd0, 4'd5, 4'd7};
      3'd5:    ks = {4'd1, 4'd3, 4'd8};
      default: ks = {4'd0, 4'd0, 4'd0};
    endcase
    return ks;
  endfunction

  // Matrix address {col,row} of element k of the 3x3 minor without row dr, column dc.
  function automatic logic [3:0] elem_addr(input logic [1:0] dr, input logic [1:0] dc,
                                           input logic [3:0] k);
    logic [1:0] i;
    logic [1:0] j;
    logic [1:0] row;
    logic [1:0] col;
    unique case (k)
      4'd0:    begin i = 2'd0; j = 2'd0; end
      4'd1:    begin i = 2'd0; j = 2'd1; end
      4'd2:    begin i = 2'd0; j = 2'd2; end
      4'd3:    begin i = 2'd1; j = 2'd0; end
      4'd4:    begin i = 2'd1; j = 2'd1; end
      4'd5:    begin i = 2'd1; j = 2'd2; end
      4'd6:    begin i = 2'd2; j = 2'd0; end
      4'd7:    begin i = 2'd2; j = 2'd1; end
      4'd8:    begin i = 2'd2; j = 2'd2; end
      default: begin i = 2'd0; j = 2'd0; end
    endcase
    row = (i >= dr) ? i + 2'd1 : i;
    col = (j >= dc) ? j + 2'd1 : j;
    return {col, row};
  endfunction

  // Saturate the accumulator to the element range.
  function automatic logic [ElemW-1:0] sat_acc(input logic [AccW-1:0] v);
    logic [AccW-ElemW:0] top;
    logic [ElemW-1:0]    res;
    top = v[AccW-1:ElemW-1];
    if ((&top) || !(|top)) begin
      res = v[ElemW-1:0];
    end else if (v[AccW-1]) begin
      res = {1'b1, {(ElemW-1){1'b0}}};
    end else begin
      res = {1'b0, {(ElemW-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: hdl/minv_ctrl.sv
`default_nettype none

module minv_ctrl
  import minv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] column_number_o,
  output logic       last_column_o,
  input  sts_t       sts_i,
  output cmd_t       cmd_o
);

  state_e     state_q, state_d;
  phase_e     phase_q, phase_d;
  logic [3:0] m_q, m_d;
  logic [2:0] t_q, t_d;
  logic       half_q, half_d;
  logic [1:0] r_q, r_d;
  logic [1:0] c_q, c_d;
  logic [1:0] load_q, load_d;
  logic [2:0][3:0] ks;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_MINOR;
      m_q     <= '0;
      t_q     <= '0;
      half_q  <= 1'b0;
      r_q     <= '0;
      c_q     <= '0;
      load_q  <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      m_q     <= m_d;
      t_q     <= t_d;
      half_q  <= half_d;
      r_q     <= r_d;
      c_q     <= c_d;
      load_q  <= load_d;
    end
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    m_d     = m_q;
    t_d     = t_q;
    half_d  = half_q;
    r_d     = r_q;
    c_d     = c_q;
    load_d  = load_q;
    cmd_o   = '0;
    ks      = term_ks(t_q);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load     = 1'b1;
          cmd_o.load_col = load_q;
          load_d         = load_q + 2'd1;
          if (load_q == 2'd3) begin
            state_d = ST_CLEAR;
            phase_d = PH_MINOR;
            m_d     = '0;
          end
        end
      end
      ST_CLEAR: begin
        cmd_o.acc_clr = 1'b1;
        t_d           = '0;
        half_d        = 1'b0;
        r_d           = '0;
        state_d       = ST_ISSUE;
      end
      ST_ISSUE: begin
        cmd_o.issue = 1'b1;
        state_d     = ST_WAIT;
        unique case (phase_q)
          PH_MINOR: begin
            // first pass forms a*b, second scales it by c and accumulates
            if (!half_q) begin
              cmd_o.opa       = OPA_MAT;
              cmd_o.opb       = OPB_MAT;
              cmd_o.mat_addr0 = elem_addr(m_q[3:2], m_q[1:0], ks[0]);
              cmd_o.mat_addr1 = elem_addr(m_q[3:2], m_q[1:0], ks[1]);
              cmd_o.dest      = DST_TMP;
            end else begin
              cmd_o.opa       = OPA_TMP;
              cmd_o.opb       = OPB_MAT;
              cmd_o.mat_addr1 = elem_addr(m_q[3:2], m_q[1:0], ks[2]);
              cmd_o.dest      = (t_q >= 3'd3) ? DST_SUB : DST_ADD;
            end
          end
          PH_DET: begin
            cmd_o.opa       = OPA_MAT;
            cmd_o.opb       = OPB_COF;
            cmd_o.mat_addr0 = {2'd0, r_q};
            cmd_o.cof_addr  = {r_q, 2'd0};
            cmd_o.dest      = DST_ADD;
          end
          PH_INV: begin
            cmd_o.opa      = OPA_COF;
            cmd_o.opb      = OPB_RECIP;
            cmd_o.cof_addr = {c_q, r_q};
            cmd_o.dest     = DST_OUT;
            cmd_o.slot     = r_q;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_WAIT: begin
        if (!sts_i.pipe_busy) begin
          unique case (phase_q)
            PH_MINOR: begin
              if (!half_q) begin
                half_d  = 1'b1;
                state_d = ST_ISSUE;
              end else begin
                half_d = 1'b0;
                if (t_q == 3'd5) begin
                  state_d = ST_COF_WR;
                end else begin
                  t_d     = t_q + 3'd1;
                  state_d = ST_ISSUE;
                end
              end
            end
            PH_DET: begin
              if (r_q == 2'd3) begin
                state_d = ST_DET_WR;
              end else begin
                r_d     = r_q + 2'd1;
                state_d = ST_ISSUE;
              end
            end
            PH_INV: begin
              if (r_q == 2'd3) begin
                state_d = ST_OUT;
              end else begin
                r_d     = r_q + 2'd1;
                state_d = ST_ISSUE;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_COF_WR: begin
        cmd_o.cof_wr   = 1'b1;
        cmd_o.cof_addr = m_q;
        cmd_o.cof_neg  = m_q[2] ^ m_q[0];
        m_d            = m_q + 4'd1;
        state_d        = ST_CLEAR;
        if (m_q == 4'd15) begin
          phase_d = PH_DET;
        end
      end
      ST_DET_WR: begin
        cmd_o.det_wr = 1'b1;
        state_d      = ST_DIV_START;
      end
      ST_DIV_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (!sts_i.div_busy) begin
          phase_d = PH_INV;
          c_d     = '0;
          r_d     = '0;
          state_d = ST_ISSUE;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          if (c_q == 2'd3) begin
            state_d = ST_IDLE;
          end else begin
            c_d     = c_q + 2'd1;
            r_d     = '0;
            state_d = ST_ISSUE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = (state_q == ST_OUT);
  assign column_number_o = c_q;
  assign last_column_o   = (c_q == 2'd3);

endmodule

`default_nettype wire

// File: hdl/minv_dp.sv
`default_nettype none

module minv_dp
  import minv_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  input  logic [ElemW-1:0] elem_x_i,
  input  logic [ElemW-1:0] elem_y_i,
  input  logic [ElemW-1:0] elem_z_i,
  input  logic [ElemW-1:0] elem_w_i,
  output logic [ElemW-1:0] inv_x_o,
  output logic [ElemW-1:0] inv_y_o,
  output logic [ElemW-1:0] inv_z_o,
  output logic [ElemW-1:0] inv_w_o,
  output logic [ElemW-1:0] det_value_o,
  output logic             singular_o
);

  localparam logic [ElemW-1:0] MaxVal = {1'b0, {(ElemW-1){1'b1}}};
  localparam logic [ElemW-1:0] MinVal = {1'b1, {(ElemW-1){1'b0}}};

  // matrix rows are columns of the loaded matrix, cofactors at {row,col}
  logic [3:0][ElemW-1:0] mat_mem [4];
  logic [OpndW-1:0]      cof_mem [16];

  logic [3:0][ElemW-1:0] mat_row0_q, mat_row1_q;
  logic [1:0]            sel0_q, sel1_q;
  logic [OpndW-1:0]      cof_rd_q;

  logic       v1_q, v2_q, v3_q, v4_q;
  opa_sel_e   opa1_q;
  opb_sel_e   opb1_q;
  dest_e      dest1_q, dest2_q, dest3_q, dest4_q;
  logic [1:0] slot1_q, slot2_q, slot3_q, slot4_q;

  logic signed [OpndW-1:0] opa, opb;
  logic [OpndW-1:0]        mag_a_q, mag_b_q;
  logic                    neg2_q, neg3_q;
  logic [ProdW-1:0]        prod_q;
  logic [ProdW:0]          prod_rnd;
  logic [ProdW-FracBits:0] q_rnd;
  logic [ElemW-1:0]        res_d, res_q;

  logic [ElemW-1:0]      tmp_q;
  logic [AccW-1:0]       acc_q;
  logic [ElemW-1:0]      det_q;
  logic [ElemW-1:0]      recip_q;
  logic [3:0][ElemW-1:0] outbuf_q;
  logic [ElemW-1:0]      minor;
  logic [OpndW-1:0]      minor_ext;
  logic [AccW-1:0]       res_ext;

  logic                 div_busy_q;
  logic [DivCntW-1:0]   div_cnt_q;
  logic [DivW-1:0]      div_num_q;
  logic [ElemW-1:0]     div_rem_q;
  logic [ElemW-1:0]     div_d_q;
  logic [ElemW-1:0]     det_mag;
  logic [ElemW:0]       div_trial;
  logic                 div_ge;
  logic [ElemW-1:0]     recip_d;

  // storage
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mat_mem[cmd_i.load_col] <= {elem_w_i, elem_z_i, elem_y_i, elem_x_i};
    end
    if (cmd_i.cof_wr) begin
      cof_mem[cmd_i.cof_addr] <= cmd_i.cof_neg ? -minor_ext : minor_ext;
    end
    mat_row0_q <= mat_mem[cmd_i.mat_addr0[3:2]];
    mat_row1_q <= mat_mem[cmd_i.mat_addr1[3:2]];
    sel0_q     <= cmd_i.mat_addr0[1:0];
    sel1_q     <= cmd_i.mat_addr1[1:0];
    cof_rd_q   <= cof_mem[cmd_i.cof_addr];
  end

  assign minor     = sat_acc(acc_q);
  assign minor_ext = {minor[ElemW-1], minor};

  // multiply pipeline: read, operands, product, rounding, write back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_comb begin
    unique case (opa1_q)
      OPA_MAT: opa = $signed({mat_row0_q[sel0_q][ElemW-1], mat_row0_q[sel0_q]});
      OPA_TMP: opa = $signed({tmp_q[ElemW-1], tmp_q});
      OPA_COF: opa = $signed(cof_rd_q);
      default: opa = '0;
    endcase
    unique case (opb1_q)
      OPB_MAT:   opb = $signed({mat_row1_q[sel1_q][ElemW-1], mat_row1_q[sel1_q]});
      OPB_COF:   opb = $signed(cof_rd_q);
      OPB_RECIP: opb = $signed({recip_q[ElemW-1], recip_q});
      default:   opb = '0;
    endcase
  end

  assign prod_rnd = {1'b0, prod_q} + ((ProdW+1)'(1) << (FracBits - 1));
  assign q_rnd    = prod_rnd[ProdW:FracBits];

  always_comb begin
    if (|q_rnd[ProdW-FracBits:ElemW-1]) begin
      res_d = neg3_q ? MinVal : MaxVal;
    end else begin
      res_d = neg3_q ? -q_rnd[ElemW-1:0] : q_rnd[ElemW-1:0];
    end
  end

  assign res_ext = {{(AccW-ElemW){res_q[ElemW-1]}}, res_q};

  always_ff @(posedge clk_i) begin
    opa1_q  <= cmd_i.opa;
    opb1_q  <= cmd_i.opb;
    dest1_q <= cmd_i.dest;
    slot1_q <= cmd_i.slot;
    mag_a_q <= opa[OpndW-1] ? OpndW'(-opa) : OpndW'(opa);
    mag_b_q <= opb[OpndW-1] ? OpndW'(-opb) : OpndW'(opb);
    neg2_q  <= opa[OpndW-1] ^ opb[OpndW-1];
    dest2_q <= dest1_q;
    slot2_q <= slot1_q;
    prod_q  <= mag_a_q * mag_b_q;
    neg3_q  <= neg2_q;
    dest3_q <= dest2_q;
    slot3_q <= slot2_q;
    res_q   <= res_d;
    dest4_q <= dest3_q;
    slot4_q <= slot3_q;
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (v4_q && dest4_q == DST_ADD) begin
      acc_q <= acc_q + res_ext;
    end else if (v4_q && dest4_q == DST_SUB) begin
      acc_q <= acc_q - res_ext;
    end
    if (v4_q && dest4_q == DST_TMP) begin
      tmp_q <= res_q;
    end
    if (v4_q && dest4_q == DST_OUT) begin
      outbuf_q[slot4_q] <= res_q;
    end
    if (cmd_i.det_wr) begin
      det_q <= minor;
    end
  end

  // reciprocal: restoring division of 2^(2F) + |det|/2 by |det|, one bit a cycle
  assign det_mag   = det_q[ElemW-1] ? -det_q : det_q;
  assign div_trial = {div_rem_q, div_num_q[DivW-1]};
  assign div_ge    = (div_trial >= {1'b0, div_d_q});

  always_comb begin
    if (det_q == '0) begin
      recip_d = '0;
    end else if (|div_num_q[DivW-1:ElemW-1]) begin
      recip_d = det_q[ElemW-1] ? MinVal : MaxVal;
    end else begin
      recip_d = det_q[ElemW-1] ? -div_num_q[ElemW-1:0] : div_num_q[ElemW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
    end else if (cmd_i.div_start) begin
      div_busy_q <= 1'b1;
      div_cnt_q  <= DivCntW'(DivW);
    end else if (div_busy_q) begin
      if (div_cnt_q != '0) begin
        div_cnt_q <= div_cnt_q - 1'b1;
      end else begin
        div_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      div_num_q <= (DivW'(1) << (2 * FracBits)) + DivW'(det_mag >> 1);
      div_rem_q <= '0;
      div_d_q   <= det_mag;
    end else if (div_busy_q) begin
      if (div_cnt_q != '0) begin
        div_rem_q <= div_ge ? ElemW'(div_trial - {1'b0, div_d_q}) : ElemW'(div_trial);
        div_num_q <= {div_num_q[DivW-2:0], div_ge};
      end else begin
        recip_q <= recip_d;
      end
    end
  end

  assign sts_o.pipe_busy = v1_q | v2_q | v3_q | v4_q;
  assign sts_o.div_busy  = div_busy_q;

  assign inv_x_o     = outbuf_q[0];
  assign inv_y_o     = outbuf_q[1];
  assign inv_z_o     = outbuf_q[2];
  assign inv_w_o     = outbuf_q[3];
  assign det_value_o = det_q;
  assign singular_o  = (det_q == '0);

endmodule

`default_nettype wire

// File: hdl/matrix_inverse_4x4_unit.sv
// 4x4 matrix inverse by adjugate in signed Q16.16. Send the matrix as four
// column requests, column 0 first; the first three are taken without a stall
// and give no result. After the fourth the unit computes the sixteen 3x3
// minors (twelve rounded products each), the determinant (four products), the
// reciprocal of the determinant in a bit-serial divider and the sixteen
// inverse elements, then returns four column results, column 0 first, each
// with the saturated determinant. All products go through one shared
// multiplier pipeline of five stages that runs one product at a time. No
// request is taken until the last result column has been accepted. A zero
// determinant raises singular and gives all-zero columns. Every value
// saturates to the 32-bit range.
`default_nettype none

`include "matrix_inverse_4x4_unit_macros.svh"

module matrix_inverse_4x4_unit
  import minv_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ElemW-1:0] elem_x_i,
  input  logic [ElemW-1:0] elem_y_i,
  input  logic [ElemW-1:0] elem_z_i,
  input  logic [ElemW-1:0] elem_w_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ElemW-1:0] inv_x_o,
  output logic [ElemW-1:0] inv_y_o,
  output logic [ElemW-1:0] inv_z_o,
  output logic [ElemW-1:0] inv_w_o,
  output logic [1:0]       column_number_o,
  output logic [ElemW-1:0] det_value_o,
  output logic             singular_o,
  output logic             last_column_o
);

  cmd_t cmd;
  sts_t sts;
  logic inv_zero;

  minv_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .column_number_o(column_number_o),
    .last_column_o  (last_column_o),
    .sts_i          (sts),
    .cmd_o          (cmd)
  );

  minv_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .elem_x_i   (elem_x_i),
    .elem_y_i   (elem_y_i),
    .elem_z_i   (elem_z_i),
    .elem_w_i   (elem_w_i),
    .inv_x_o    (inv_x_o),
    .inv_y_o    (inv_y_o),
    .inv_z_o    (inv_z_o),
    .inv_w_o    (inv_w_o),
    .det_value_o(det_value_o),
    .singular_o (singular_o)
  );

  assign inv_zero = (inv_x_o == '0) && (inv_y_o == '0) && (inv_z_o == '0) && (inv_w_o == '0);

  `MINV_ASSERT_NEVER(a_issue_while_busy, clk_i, rst_ni, cmd.issue && sts.pipe_busy)
  `MINV_ASSERT_NEVER(a_in_open_during_out, clk_i, rst_ni, !in_stall_o && out_valid_o)
  `MINV_ASSERT(a_singular_zero, clk_i, rst_ni, (out_valid_o && singular_o) |-> inv_zero)
  `MINV_ASSERT(a_col_gap, clk_i, rst_ni, (out_valid_o && !out_stall_i && !last_column_o) |=> !out_valid_o)

endmodule

`default_nettype wire

// File: test/tb.sv
`default_nettype none

typedef struct {
  logic [31:0] x;
  logic [31:0] y;
  logic [31:0] z;
  logic [31:0] w;
  logic [1:0]  col;
  logic [31:0] det;
  logic        sing;
  logic        last;
} inv_col_t;

class inverse_scoreboard;
  int          mat[4][4];  // [col][row]
  int unsigned load_col;
  inv_col_t    expected_q[$];
  int          errors;

  function new();
    load_col = 0;
    errors   = 0;
  endfunction

  function longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Round half away from zero after the Q16 shift, then saturate.
  function longint qmul(longint a, longint b);
    bit     neg;
    longint ua;
    longint ub;
    longint q;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? -a : a;
    ub  = (b < 0) ? -b : b;
    q   = (ua * ub + 64'sd32768) >>> 16;
    if (q > 64'sd2147483648) q = 64'sd2147483648;
    return clamp32(neg ? -q : q);
  endfunction

  function longint minor3(int dr, int dc);
    longint e[9];
    int     k;
    k = 0;
    for (int r = 0; r < 4; r++) begin
      if (r == dr) continue;
      for (int c = 0; c < 4; c++) begin
        if (c == dc) continue;
        e[k] = mat[c][r];
        k++;
      end
    end
    return clamp32(qmul(qmul(e[0], e[4]), e[8]) + qmul(qmul(e[1], e[5]), e[6])
                 + qmul(qmul(e[2], e[3]), e[7]) - qmul(qmul(e[6], e[4]), e[2])
                 - qmul(qmul(e[7], e[5]), e[0]) - qmul(qmul(e[8], e[3]), e[1]));
  endfunction

  function void note_column(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [31:0] w);
    longint   cof[4][4];
    longint   det;
    longint   recip;
    longint   ud;
    longint   q;
    inv_col_t res;
    mat[load_col][0] = x;
    mat[load_col][1] = y;
    mat[load_col][2] = z;
    mat[load_col][3] = w;
    if (load_col != 3) begin
      load_col++;
      return;
    end
    load_col = 0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        cof[r][c] = ((r + c) % 2) ? -minor3(r, c) : minor3(r, c);
      end
    end
    det = 0;
    for (int r = 0; r < 4; r++) det += qmul(mat[0][r], cof[r][0]);
    det   = clamp32(det);
    recip = 0;
    if (det != 0) begin
      ud = (det < 0) ? -det : det;
      q  = (64'sd4294967296 + (ud >>> 1)) / ud;
      if (q > 64'sd2147483648) q = 64'sd2147483648;
      recip = clamp32((det < 0) ? -q : q);
    end
    for (int c = 0; c < 4; c++) begin
      res.x    = (det == 0) ? 32'd0 : 32'(qmul(cof[c][0], recip));
      res.y    = (det == 0) ? 32'd0 : 32'(qmul(cof[c][1], recip));
      res.z    = (det == 0) ? 32'd0 : 32'(qmul(cof[c][2], recip));
      res.w    = (det == 0) ? 32'd0 : 32'(qmul(cof[c][3], recip));
      res.col  = 2'(c);
      res.det  = 32'(det);
      res.sing = (det == 0);
      res.last = (c == 3);
      expected_q.push_back(res);
    end
  endfunction

  function void check_column(inv_col_t act);
    inv_col_t exp_c;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result column %0d", $time, act.col);
      errors++;
      return;
    end
    exp_c = expected_q.pop_front();
    if (exp_c.x !== act.x) report("inv_x", exp_c.x, act.x);
    if (exp_c.y !== act.y) report("inv_y", exp_c.y, act.y);
    if (exp_c.z !== act.z) report("inv_z", exp_c.z, act.z);
    if (exp_c.w !== act.w) report("inv_w", exp_c.w, act.w);
    if (exp_c.col !== act.col) report("column_number", 32'(exp_c.col), 32'(act.col));
    if (exp_c.det !== act.det) report("det_value", exp_c.det, act.det);
    if (exp_c.sing !== act.sing) report("singular", 32'(exp_c.sing), 32'(act.sing));
    if (exp_c.last !== act.last) report("last_column", 32'(exp_c.last), 32'(act.last));
  endfunction

  function void report(string name, logic [31:0] e, logic [31:0] a);
    $display("%0t: %s expected %h actual %h", $time, name, e, a);
    errors++;
  endfunction
endclass

module tb;
  import minv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [ElemW-1:0] elem_x_i = '0;
  logic [ElemW-1:0] elem_y_i = '0;
  logic [ElemW-1:0] elem_z_i = '0;
  logic [ElemW-1:0] elem_w_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [ElemW-1:0] inv_x_o;
  logic [ElemW-1:0] inv_y_o;
  logic [ElemW-1:0] inv_z_o;
  logic [ElemW-1:0] inv_w_o;
  logic [1:0]       column_number_o;
  logic [ElemW-1:0] det_value_o;
  logic             singular_o;
  logic             last_column_o;

  inverse_scoreboard sb = new();
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int unsigned quiet_cycles = 0;

  matrix_inverse_4x4_unit u_dut (.*);

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    inv_col_t act;
    if (out_valid_o && !out_stall_i) begin
      act.x    = inv_x_o;
      act.y    = inv_y_o;
      act.z    = inv_z_o;
      act.w    = inv_w_o;
      act.col  = column_number_o;
      act.det  = det_value_o;
      act.sing = singular_o;
      act.last = last_column_o;
      sb.check_column(act);
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: column traffic in or out clears the quiet counter; when it reaches its limit the run ends as a mismatch.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 30000) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_column(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [31:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    elem_x_i   <= x;
    elem_y_i   <= y;
    elem_z_i   <= z;
    elem_w_i   <= w;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_column(x, y, z, w);
  endtask

  // Send a matrix whose every entry is a, with b on the diagonal.
  task automatic send_pattern(logic [31:0] a, logic [31:0] b);
    for (int c = 0; c < 4; c++) begin
      send_column(c == 0 ? b : a, c == 1 ? b : a, c == 2 ? b : a, c == 3 ? b : a);
    end
  endtask

  function automatic logic [31:0] rand_elem();
    if ($urandom_range(99) < 15) return $urandom;
    return $urandom_range(32'h8_0000) - 32'h4_0000;
  endfunction

  task automatic send_random_matrix();
    for (int c = 0; c < 4; c++) send_column(rand_elem(), rand_elem(), rand_elem(), rand_elem());
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pattern(32'h0, 32'h1_0000);           // identity
    send_pattern(32'h0, 32'h0);                // all zero, singular
    send_pattern(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_pattern(32'h8000_0000, 32'h8000_0000);
    send_pattern(32'h0, 32'h1);                // determinant rounds to zero
    send_pattern(32'hFFFF_8000, 32'h7FFF_0000); // saturating entries

    send_idle_pct  = 6;
    recv_stall_pct = 45;
    for (int i = 0; i < 9; i++) send_random_matrix();

    // Hold off until every result of the earlier matrices is back.
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);

    send_idle_pct  = 45;
    recv_stall_pct = 6;
    for (int i = 0; i < 9; i++) send_random_matrix();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 10; i++) send_random_matrix();
    in_valid_i <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

`default_nettype wire
